@@ design/cascaded_pid_steering_defines.svh @@
// Assertion macros for the cascaded_pid_steering checker.
// No dependencies; included by bare file name.
`ifndef CASCADED_PID_STEERING_DEFINES_SVH
`define CASCADED_PID_STEERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cps_pkg.sv @@
// Types and constants for the cascaded PID steering block.
// No dependencies; imported by every module of the block.
package cps_pkg;

    localparam int POSITION_TARGET = 240;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 10;
    localparam int LIMIT_W     = 16;
    localparam int SAMPLE_W    = 16;
    localparam int DRIVE_W     = 32;
    localparam int ERR_W       = 18;
    localparam int SUM_W       = 31;

    typedef enum logic {
        CMD_CAMERA = 1'b0,
        CMD_GYRO   = 1'b1
    } cps_cmd_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INNER_KP      = 3'd0,
        REG_INNER_KI      = 3'd1,
        REG_INNER_KD      = 3'd2,
        REG_INNER_I_LIMIT = 3'd3,
        REG_OUTER_KP      = 3'd4,
        REG_OUTER_KI      = 3'd5,
        REG_OUTER_KD      = 3'd6,
        REG_OUTER_I_LIMIT = 3'd7
    } cps_reg_e;

    localparam logic [GAIN_W-1:0]  INNER_KP_RST      = 10'd350;
    localparam logic [GAIN_W-1:0]  INNER_KI_RST      = 10'd15;
    localparam logic [GAIN_W-1:0]  INNER_KD_RST      = 10'd0;
    localparam logic [LIMIT_W-1:0] INNER_I_LIMIT_RST = 16'd10;
    localparam logic [GAIN_W-1:0]  OUTER_KP_RST      = 10'd1;
    localparam logic [GAIN_W-1:0]  OUTER_KI_RST      = 10'd0;
    localparam logic [GAIN_W-1:0]  OUTER_KD_RST      = 10'd0;
    localparam logic [LIMIT_W-1:0] OUTER_I_LIMIT_RST = 16'd1000;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] i_limit;
    } cps_gains_t;

    typedef struct packed {
        cps_gains_t inner_loop;
        cps_gains_t outer_loop;
    } cps_cfg_t;

endpackage

@@ design/cps_pid_calc.sv @@
// One PID evaluation: clamped integral update and the three-term sum.
// Depends on cps_pkg.
module cps_pid_calc
    import cps_pkg::*;
(
    input  cps_gains_t                gains_i,
    input  logic signed [ERR_W-1:0]   err_i,
    input  logic signed [ERR_W-1:0]   integ_i,
    input  logic signed [ERR_W-1:0]   last_i,
    output logic signed [ERR_W-1:0]   integ_o,
    output logic signed [SUM_W-1:0]   sum_o
);

    logic signed [ERR_W:0]          acc;
    logic signed [ERR_W:0]          lim_pos;
    logic signed [ERR_W:0]          lim_neg;
    logic signed [ERR_W:0]          acc_clamped;
    logic signed [ERR_W:0]          diff;
    logic signed [GAIN_W:0]         kp_s;
    logic signed [GAIN_W:0]         ki_s;
    logic signed [GAIN_W:0]         kd_s;
    logic signed [GAIN_W+ERR_W:0]   p_term;
    logic signed [GAIN_W+ERR_W:0]   i_term;
    logic signed [GAIN_W+ERR_W+1:0] d_term;

    always_comb begin
        acc     = $signed({integ_i[ERR_W-1], integ_i}) + $signed({err_i[ERR_W-1], err_i});
        lim_pos = $signed({{(ERR_W+1-LIMIT_W){1'b0}}, gains_i.i_limit});
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            acc_clamped = lim_pos;
        end else if (acc < lim_neg) begin
            acc_clamped = lim_neg;
        end else begin
            acc_clamped = acc;
        end
    end

    assign integ_o = acc_clamped[ERR_W-1:0];

    assign kp_s = $signed({1'b0, gains_i.kp});
    assign ki_s = $signed({1'b0, gains_i.ki});
    assign kd_s = $signed({1'b0, gains_i.kd});
    assign diff = $signed({err_i[ERR_W-1], err_i}) - $signed({last_i[ERR_W-1], last_i});

    assign p_term = (GAIN_W+ERR_W+1)'(kp_s) * (GAIN_W+ERR_W+1)'(err_i);
    assign i_term = (GAIN_W+ERR_W+1)'(ki_s) * (GAIN_W+ERR_W+1)'(integ_o);
    assign d_term = (GAIN_W+ERR_W+2)'(kd_s) * (GAIN_W+ERR_W+2)'(diff);

    assign sum_o = $signed({{2{p_term[GAIN_W+ERR_W]}}, p_term})
                 + $signed({{2{i_term[GAIN_W+ERR_W]}}, i_term})
                 + $signed({d_term[GAIN_W+ERR_W+1], d_term});

endmodule

@@ design/cps_cfg_regs.sv @@
// Gain and integral-limit register file, written through a plain write port.
// Depends on cps_pkg.
module cps_cfg_regs
    import cps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en_i,
    input  logic [CFG_INDEX_W-1:0] index_i,
    input  logic [CFG_DATA_W-1:0]  wdata_i,
    output cps_cfg_t               cfg_o
);

    cps_cfg_t cfg_reg;
    cps_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en_i) begin
            case (cps_reg_e'(index_i))
                REG_INNER_KP:      cfg_next.inner_loop.kp      = wdata_i[GAIN_W-1:0];
                REG_INNER_KI:      cfg_next.inner_loop.ki      = wdata_i[GAIN_W-1:0];
                REG_INNER_KD:      cfg_next.inner_loop.kd      = wdata_i[GAIN_W-1:0];
                REG_INNER_I_LIMIT: cfg_next.inner_loop.i_limit = wdata_i[LIMIT_W-1:0];
                REG_OUTER_KP:      cfg_next.outer_loop.kp      = wdata_i[GAIN_W-1:0];
                REG_OUTER_KI:      cfg_next.outer_loop.ki      = wdata_i[GAIN_W-1:0];
                REG_OUTER_KD:      cfg_next.outer_loop.kd      = wdata_i[GAIN_W-1:0];
                REG_OUTER_I_LIMIT: cfg_next.outer_loop.i_limit = wdata_i[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inner_loop.kp      <= INNER_KP_RST;
            cfg_reg.inner_loop.ki      <= INNER_KI_RST;
            cfg_reg.inner_loop.kd      <= INNER_KD_RST;
            cfg_reg.inner_loop.i_limit <= INNER_I_LIMIT_RST;
            cfg_reg.outer_loop.kp      <= OUTER_KP_RST;
            cfg_reg.outer_loop.ki      <= OUTER_KI_RST;
            cfg_reg.outer_loop.kd      <= OUTER_KD_RST;
            cfg_reg.outer_loop.i_limit <= OUTER_I_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

@@ design/cps_datapath.sv @@
// Loop state (setpoint, integrals, last errors) and the two PID evaluations.
// Depends on cps_pkg and cps_pid_calc.
module cps_datapath
    import cps_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cps_cfg_t                   cfg_i,
    input  logic                       fire_i,
    input  cps_cmd_e                   cmd_i,
    input  logic signed [SAMPLE_W-1:0] sample_i,
    output logic signed [DRIVE_W-1:0]  left_o,
    output logic signed [DRIVE_W-1:0]  right_o
);

    logic signed [SAMPLE_W-1:0] setpoint_reg;
    logic signed [ERR_W-1:0]    inner_integ_reg;
    logic signed [ERR_W-1:0]    inner_last_reg;
    logic signed [ERR_W-1:0]    outer_integ_reg;
    logic signed [ERR_W-2:0]    outer_last_reg;

    logic signed [ERR_W-2:0]    outer_err;
    logic signed [ERR_W-1:0]    inner_err;
    logic signed [ERR_W-1:0]    outer_integ_new;
    logic signed [ERR_W-1:0]    inner_integ_new;
    logic signed [SUM_W-1:0]    outer_sum;
    logic signed [SUM_W-1:0]    inner_sum;
    logic signed [SAMPLE_W-1:0] setpoint_next;

    assign outer_err = $signed((ERR_W-1)'(POSITION_TARGET))
                     - $signed({sample_i[SAMPLE_W-1], sample_i});
    assign inner_err = $signed({{2{setpoint_reg[SAMPLE_W-1]}}, setpoint_reg})
                     - $signed({{2{sample_i[SAMPLE_W-1]}}, sample_i});

    cps_pid_calc u_outer (
        .gains_i (cfg_i.outer_loop),
        .err_i   ($signed({outer_err[ERR_W-2], outer_err})),
        .integ_i (outer_integ_reg),
        .last_i  ($signed({outer_last_reg[ERR_W-2], outer_last_reg})),
        .integ_o (outer_integ_new),
        .sum_o   (outer_sum)
    );

    cps_pid_calc u_inner (
        .gains_i (cfg_i.inner_loop),
        .err_i   (inner_err),
        .integ_i (inner_integ_reg),
        .last_i  (inner_last_reg),
        .integ_o (inner_integ_new),
        .sum_o   (inner_sum)
    );

    always_comb begin
        if (outer_sum > $signed(SUM_W'(32767))) begin
            setpoint_next = 16'sh7FFF;
        end else if (outer_sum < -$signed(SUM_W'(32768))) begin
            setpoint_next = 16'sh8000;
        end else begin
            setpoint_next = outer_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= '0;
            inner_integ_reg <= '0;
            inner_last_reg  <= '0;
            outer_integ_reg <= '0;
            outer_last_reg  <= '0;
        end else if (fire_i) begin
            if (cmd_i == CMD_CAMERA) begin
                outer_integ_reg <= outer_integ_new;
                outer_last_reg  <= outer_err;
                setpoint_reg    <= setpoint_next;
            end else begin
                inner_integ_reg <= inner_integ_new;
                inner_last_reg  <= inner_err;
            end
        end
    end

    // |sum| < 2^30, so the 32-bit sign extension and the negation never clip
    assign right_o = $signed({inner_sum[SUM_W-1], inner_sum});
    assign left_o  = -right_o;

endmodule

@@ design/cascaded_pid_steering.sv @@
// Top level of the cascaded PID steering block: handshakes, input and result registers.
// Depends on cps_pkg, cps_cfg_regs, cps_datapath.
//
// Input channel s_*: one beat per sample. s_command selects a camera position
// sample (outer position loop) or a gyro z rate sample (inner rate loop).
// Camera beats update the rate setpoint and produce no result beat. Each gyro
// beat produces exactly one result beat on m_* with m_right_drive = inner PID
// sum and m_left_drive = its negation.
// A gyro beat goes into the sample register, then its result into the result register.
// Throughput: one beat per cycle while the receiver does not stall; the sample register
// feeds a single combinational PID pass whose state updates at the same edge as the
// result register, so the next sample sees it at once.
// Receiver stall: the result register holds; a gyro beat waits in the sample
// register and s_ready drops only while both are full. Camera beats still
// flow under stall.
// Reset (aresetn low, synchronous): gains and limits return to their
// defaults, setpoint, integrals and last errors clear, no beat is pending.
// Configuration writes on cfg_* take effect at the next edge; write only when idle.
module cascaded_pid_steering
    import cps_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DRIVE_W-1:0]  m_left_drive,
    output logic signed [DRIVE_W-1:0]  m_right_drive
);

    cps_cfg_t                   cfg;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    cps_cmd_e                   in_cmd_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [DRIVE_W-1:0]  left_reg;
    logic signed [DRIVE_W-1:0]  right_reg;
    logic signed [DRIVE_W-1:0]  left_next;
    logic signed [DRIVE_W-1:0]  right_next;
    logic                       out_free;
    logic                       fire;
    logic                       fire_gyro;

    cps_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en_i (cfg_wr_en),
        .index_i (cfg_index),
        .wdata_i (cfg_wdata),
        .cfg_o   (cfg)
    );

    cps_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_i    (cfg),
        .fire_i   (fire),
        .cmd_i    (in_cmd_reg),
        .sample_i (in_sample_reg),
        .left_o   (left_next),
        .right_o  (right_next)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && ((in_cmd_reg == CMD_CAMERA) || out_free);
    assign fire_gyro = fire && (in_cmd_reg == CMD_GYRO);
    assign s_ready   = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        m_valid_next = m_valid_reg;
        if (fire_gyro) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= cps_cmd_e'(s_command);
            in_sample_reg <= s_sample;
        end
        if (fire_gyro) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = left_reg;
    assign m_right_drive = right_reg;

endmodule

@@ design/cps_checker.sv @@
// Port-level checker for cascaded_pid_steering, bound to the top level.
// Depends on cps_pkg and cascaded_pid_steering_defines.svh.
`include "cascaded_pid_steering_defines.svh"

module cps_checker
    import cps_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_command,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [DRIVE_W-1:0]  m_left_drive,
    input logic signed [DRIVE_W-1:0]  m_right_drive
);

    `CPS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_left_drive) && $stable(m_right_drive), "result beat changed while stalled")

    `CPS_ASSERT_NOW(a_drive_mirror, aclk, aresetn, m_valid, (m_left_drive + m_right_drive) == 32'sd0, "left drive is not the negated right drive")

    `CPS_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready && (s_command == CMD_GYRO), 2), "result beat without a gyro beat two cycles earlier")

endmodule

bind cascaded_pid_steering cps_checker u_cps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_command     (s_command),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_drive  (m_left_drive),
    .m_right_drive (m_right_drive)
);
